// File: rtl/core/pq_asymmetric_distance_topk_macros.svh
// Assertion helpers for the PQ distance search block.
// Each macro expects clk and rst in scope.
`ifndef PQ_ASYMMETRIC_DISTANCE_TOPK_MACROS_SVH
`define PQ_ASYMMETRIC_DISTANCE_TOPK_MACROS_SVH

// Same-cycle implication.
`define PQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pqadt_pkg.sv
// ----------------------------------------------------------------------------
// pqadt_pkg
// Shared types, field widths and helpers for the PQ distance search block.
// ----------------------------------------------------------------------------
package pqadt_pkg;

  localparam int OPCODE_W   = 2;
  localparam int SUBSPACE_W = 6;
  localparam int LANE_W     = 4;
  localparam int CENTROID_W = 8;
  localparam int VALUE_W    = 32;
  localparam int CODE_W     = 8;
  localparam int ID_W       = 32;
  localparam int RANK_W     = 5;
  localparam int DIST_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_QUERY    = 2'd0,
    OP_CODEBOOK = 2'd1,
    OP_CODE     = 2'd2,
    OP_FINISH   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SUBSPACES  = 2'd0,
    CFG_SUBSPACE_WIDTH = 2'd1,
    CFG_CODEBOOK_SIZE  = 2'd2,
    CFG_KEEP_COUNT     = 2'd3
  } cfg_index_t;

  // Add with saturation at all ones.
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

// File: rtl/core/pqadt_if.sv
// ----------------------------------------------------------------------------
// pqadt_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pqadt_req_if import pqadt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [OPCODE_W-1:0]   opcode;
  logic        [SUBSPACE_W-1:0] subspace;
  logic        [LANE_W-1:0]     lane;
  logic        [CENTROID_W-1:0] centroid;
  logic signed [VALUE_W-1:0]    value;
  logic        [CODE_W-1:0]     code;
  logic        [ID_W-1:0]       vector_id;

  modport source (output valid, opcode, subspace, lane, centroid, value, code, vector_id,
                  input ready);
  modport sink   (input valid, opcode, subspace, lane, centroid, value, code, vector_id,
                  output ready);
endinterface

interface pqadt_rsp_if import pqadt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic [ID_W-1:0]   result_id;
  logic [DIST_W-1:0] distance;
  logic              last;

  modport source (output valid, rank, result_id, distance, last, input ready);
  modport sink   (input valid, rank, result_id, distance, last, output ready);
endinterface

// File: rtl/core/pqadt_ram.sv
// ----------------------------------------------------------------------------
// pqadt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqadt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pq_asymmetric_distance_topk.sv
// Flow: a query writes the query RAM; a codebook request passes S_CB_RD, S_CB_MUL, S_CB_WR;
// a code passes S_VEC_SUM and, if it completes a vector into a full buffer, walks the
// buffer RAM for its worst entry. Finish: per reported rank, a buffer scan, one or two swap
// writes and the result handshake; an empty buffer reports none. One request at a time.
// Reset (rst, synchronous): registers return to 8/4/256/16, running sum and candidate count
// clear; query, table and candidate RAMs hold garbage until written.
// ----------------------------------------------------------------------------
// pq_asymmetric_distance_topk
// PQ asymmetric distance search with top-k candidate selection.
// ----------------------------------------------------------------------------
`include "pq_asymmetric_distance_topk_macros.svh"

module pq_asymmetric_distance_topk import pqadt_pkg::*; #(
  parameter int MAX_SUBSPACES      = 64,
  parameter int MAX_SUBSPACE_WIDTH = 16,
  parameter int MAX_CODEBOOK       = 256,
  parameter int MAX_KEEP           = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pqadt_req_if.sink             req,
  pqadt_rsp_if.source           rsp
);

  // Storage geometry.
  localparam int Q_DEPTH   = MAX_SUBSPACES * MAX_SUBSPACE_WIDTH;
  localparam int QA_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int T_DEPTH   = MAX_SUBSPACES * MAX_CODEBOOK;
  localparam int TA_W      = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
  localparam int BUF_DEPTH = 2 * MAX_KEEP;
  localparam int CA_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int CAND_W    = ID_W + DIST_W;
  localparam int CW        = 9;   // width for config compares

  typedef enum logic [3:0] {
    S_IDLE, S_CB_RD, S_CB_MUL, S_CB_WR, S_VEC_SUM, S_SCAN, S_REPLACE,
    S_SORT_SCAN, S_SWAP_A, S_SWAP_B, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0] num_subspaces;
  logic [4:0] subspace_width;
  logic [8:0] codebook_size;
  logic [5:0] keep_count;

  // Clamped configuration.
  logic [CW-1:0] m_c, w_c, ks_c, keep_c, cap;

  // Latched request and working registers.
  logic [SUBSPACE_W-1:0] sub;
  logic [LANE_W-1:0]     lane;
  logic [VALUE_W-1:0]    value;
  logic [ID_W-1:0]       vid;
  logic                  code_ok;
  logic [TA_W-1:0]       taddr;
  logic [DIST_W-1:0]     tbl_old;
  logic [VALUE_W-1:0]    mag;
  logic [DIST_W-1:0]     sq;
  logic [DIST_W-1:0]     running_sum;
  logic [DIST_W-1:0]     vec_d;
  logic [CNT_W-1:0]      cand_count;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      s;
  logic [CNT_W-1:0]      n;
  logic [CA_W-1:0]       best;
  logic [DIST_W-1:0]     best_d;
  logic [ID_W-1:0]       best_id;
  logic [DIST_W-1:0]     s_d;
  logic [ID_W-1:0]       s_id;

  // Result register.
  logic [RANK_W-1:0] rsp_rank;
  logic [ID_W-1:0]   rsp_id;
  logic [DIST_W-1:0] rsp_dist;
  logic              rsp_last;

  // RAM ports.
  logic              q_we;
  logic [QA_W-1:0]   q_addr;
  logic [VALUE_W-1:0] q_rdata;
  logic              t_we;
  logic [TA_W-1:0]   t_raddr;
  logic [DIST_W-1:0] t_wdata, t_rdata;
  logic              c_we;
  logic [CA_W-1:0]   c_waddr, c_raddr;
  logic [CAND_W-1:0] c_wdata, c_rdata;

  logic [ID_W-1:0]   c_rd_id;
  logic [DIST_W-1:0] c_rd_d;
  logic              accept;
  logic [31:0]       q_addr_full, t_addr_full;
  logic              op1_ok, q_ok;
  logic signed [VALUE_W:0] diff;
  logic [DIST_W-1:0] entry, vsum;
  logic [CW-1:0]     n_next;

  assign accept  = req.valid && req.ready;
  assign c_rd_id = c_rdata[CAND_W-1:DIST_W];
  assign c_rd_d  = c_rdata[DIST_W-1:0];

  // Clamp registers into their working ranges.
  always_comb begin
    m_c    = (num_subspaces == '0) ? CW'(1) :
             ((CW'(num_subspaces) > CW'(MAX_SUBSPACES)) ? CW'(MAX_SUBSPACES)
                                                         : CW'(num_subspaces));
    w_c    = (subspace_width == '0) ? CW'(1) :
             ((CW'(subspace_width) > CW'(MAX_SUBSPACE_WIDTH)) ? CW'(MAX_SUBSPACE_WIDTH)
                                                               : CW'(subspace_width));
    ks_c   = (codebook_size == '0) ? CW'(1) :
             ((CW'(codebook_size) > CW'(MAX_CODEBOOK)) ? CW'(MAX_CODEBOOK)
                                                        : CW'(codebook_size));
    keep_c = (keep_count == '0) ? CW'(1) :
             ((CW'(keep_count) > CW'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_count));
    cap    = keep_c << 1;
    n_next = (CW'(cand_count) < keep_c) ? CW'(cand_count) : keep_c;
  end

  // Request decode: address math and range checks.
  always_comb begin
    q_addr_full = 32'(req.subspace) * 32'(MAX_SUBSPACE_WIDTH) + 32'(req.lane);
    q_ok   = (32'(req.subspace) < 32'(MAX_SUBSPACES)) &&
             (32'(req.lane) < 32'(MAX_SUBSPACE_WIDTH));
    op1_ok = (CW'(req.subspace) < m_c) && (CW'(req.lane) < w_c) &&
             (CW'(req.centroid) < ks_c);
    if (opcode_t'(req.opcode) == OP_CODEBOOK) begin
      t_addr_full = 32'(req.subspace) * 32'(MAX_CODEBOOK) + 32'(req.centroid);
    end else begin
      t_addr_full = 32'(req.subspace) * 32'(MAX_CODEBOOK) + 32'(req.code);
    end
    q_addr  = q_addr_full[QA_W-1:0];
    t_raddr = t_addr_full[TA_W-1:0];
    q_we    = accept && (opcode_t'(req.opcode) == OP_QUERY) && q_ok;
  end

  // Codebook path: 33-bit difference, then square, then accumulate.
  assign diff    = $signed({q_rdata[VALUE_W-1], q_rdata}) - $signed({value[VALUE_W-1], value});
  assign t_we    = (state == S_CB_WR);
  assign t_wdata = (lane == '0) ? sq : sat_add(tbl_old, sq);

  // Code path: a code beyond the table adds zero.
  assign entry = code_ok ? t_rdata : '0;
  assign vsum  = (sub == '0) ? entry : sat_add(running_sum, entry);

  // Candidate RAM write port: append, replace, and the two halves of a swap.
  always_comb begin
    c_we    = 1'b0;
    c_waddr = cand_count[CA_W-1:0];
    c_wdata = {vid, vsum};
    unique case (state)
      S_VEC_SUM: begin
        c_we = (CW'(sub) == m_c - CW'(1)) && (CW'(cand_count) < cap);
      end
      S_REPLACE: begin
        c_we    = vec_d < best_d;
        c_waddr = best;
        c_wdata = {vid, vec_d};
      end
      S_SWAP_A: begin
        c_we    = 1'b1;
        c_waddr = s[CA_W-1:0];
        c_wdata = {best_id, best_d};
      end
      S_SWAP_B: begin
        c_we    = 1'b1;
        c_waddr = best;
        c_wdata = {s_id, s_d};
      end
      default: begin
        c_we = 1'b0;
      end
    endcase
    c_raddr = idx[CA_W-1:0];
  end

  // Sequencer: one request at a time, state and result register together.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      num_subspaces  <= 7'd8;
      subspace_width <= 5'd4;
      codebook_size  <= 9'd256;
      keep_count     <= 6'd16;
      running_sum    <= '0;
      cand_count     <= '0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_NUM_SUBSPACES:  num_subspaces  <= cfg_data[6:0];
          CFG_SUBSPACE_WIDTH: subspace_width <= cfg_data[4:0];
          CFG_CODEBOOK_SIZE:  codebook_size  <= cfg_data[8:0];
          CFG_KEEP_COUNT:     keep_count     <= cfg_data[5:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sub     <= req.subspace;
            lane    <= req.lane;
            value   <= req.value;
            vid     <= req.vector_id;
            taddr   <= t_raddr;
            code_ok <= 32'(req.code) < 32'(MAX_CODEBOOK);
            unique case (opcode_t'(req.opcode))
              OP_QUERY: state <= S_IDLE;
              OP_CODEBOOK: begin
                if (op1_ok) state <= S_CB_RD;
              end
              OP_CODE: begin
                if (CW'(req.subspace) < m_c) state <= S_VEC_SUM;
              end
              OP_FINISH: begin
                // Empty buffer: nothing to report.
                if (n_next != '0) begin
                  n     <= CNT_W'(n_next);
                  s     <= '0;
                  idx   <= '0;
                  state <= S_SORT_SCAN;
                end
              end
            endcase
          end
        end
        S_CB_RD: begin
          tbl_old <= t_rdata;
          mag     <= diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];
          state   <= S_CB_MUL;
        end
        S_CB_MUL: begin
          sq    <= DIST_W'(mag) * DIST_W'(mag);
          state <= S_CB_WR;
        end
        S_CB_WR: begin
          state <= S_IDLE;
        end
        S_VEC_SUM: begin
          running_sum <= vsum;
          vec_d       <= vsum;
          state       <= S_IDLE;
          if (CW'(sub) == m_c - CW'(1)) begin
            if (CW'(cand_count) < cap) begin
              cand_count <= cand_count + CNT_W'(1);
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Read data is registered, so it holds entry idx-1: compare that entry.
          if (idx != '0) begin
            if (idx == CNT_W'(1) || c_rd_d > best_d) begin
              best_d <= c_rd_d;
              best   <= CA_W'(idx - CNT_W'(1));
            end
          end
          if (idx == cand_count) state <= S_REPLACE;
          else idx <= idx + CNT_W'(1);
        end
        S_REPLACE: begin
          state <= S_IDLE;
        end
        S_SORT_SCAN: begin
          if (idx != s) begin
            if (idx - CNT_W'(1) == s) begin
              best    <= s[CA_W-1:0];
              best_d  <= c_rd_d;
              best_id <= c_rd_id;
              s_d     <= c_rd_d;
              s_id    <= c_rd_id;
            end else if (c_rd_d < best_d) begin
              best    <= CA_W'(idx - CNT_W'(1));
              best_d  <= c_rd_d;
              best_id <= c_rd_id;
            end
          end
          if (idx == cand_count) state <= S_SWAP_A;
          else idx <= idx + CNT_W'(1);
        end
        S_SWAP_A: begin
          rsp_rank <= RANK_W'(s);
          rsp_id   <= best_id;
          rsp_dist <= best_d;
          rsp_last <= (s + CNT_W'(1)) == n;
          state    <= (best != s[CA_W-1:0]) ? S_SWAP_B : S_OUT;
        end
        S_SWAP_B: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until taken; then advance rank or drop the buffer.
          if (rsp.ready) begin
            if (rsp_last) begin
              cand_count <= '0;
              state      <= S_IDLE;
            end else begin
              s     <= s + CNT_W'(1);
              idx   <= s + CNT_W'(1);
              state <= S_SORT_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_OUT);
  assign rsp.rank      = rsp_rank;
  assign rsp.result_id = rsp_id;
  assign rsp.distance  = rsp_dist;
  assign rsp.last      = rsp_last;

  pqadt_ram #(.WIDTH(VALUE_W), .DEPTH(Q_DEPTH), .AW(QA_W)) u_query (
    .clk(clk), .we(q_we), .waddr(q_addr), .wdata(req.value),
    .raddr(q_addr), .rdata(q_rdata)
  );

  pqadt_ram #(.WIDTH(DIST_W), .DEPTH(T_DEPTH), .AW(TA_W)) u_table (
    .clk(clk), .we(t_we), .waddr(taddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  pqadt_ram #(.WIDTH(CAND_W), .DEPTH(BUF_DEPTH), .AW(CA_W)) u_cand (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  `PQ_ASSERT_NOW(a_count_bound, 1'b1, 32'(cand_count) <= 32'(BUF_DEPTH), "cand_count overflow")
  `PQ_ASSERT_NOW(a_scan_nonempty, state == S_SCAN || state == S_SORT_SCAN, cand_count != '0,
                 "scan over empty buffer")
  `PQ_ASSERT_NEXT(a_finish_clears, rsp.valid && rsp.ready && rsp.last, cand_count == '0,
                  "buffer not emptied after finish")
  `PQ_ASSERT_NOW(a_one_at_a_time, rsp.valid, !req.ready, "request taken while result pending")

endmodule

// File: tb/tb_pq_asymmetric_distance_topk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pq_asymmetric_distance_topk
// Self-checking bench for the PQ asymmetric distance search block. A
// directed table covers the edges, then random phases under several register
// settings drive query, codebook, code and finish requests. Every result is
// checked against an in-bench model of the distance table and the candidate
// buffer.
// ----------------------------------------------------------------------------
module tb_pq_asymmetric_distance_topk;
  import pqadt_pkg::*;

  localparam int NSUB  = 64;
  localparam int NLANE = 16;
  localparam int NCB   = 256;
  localparam int NKEEP = 32;
  localparam int NBUF  = 2 * NKEEP;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct {
    opcode_t                 op;
    logic [SUBSPACE_W-1:0]   sub;
    logic [LANE_W-1:0]       lane;
    logic [CENTROID_W-1:0]   cen;
    logic [VALUE_W-1:0]      value;
    logic [CODE_W-1:0]       code;
    logic [ID_W-1:0]         vid;
  } search_req_t;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dval;
    logic              last;
  } neighbor_t;

  // Directed row: n_typed < 0 means the model decides; otherwise the row
  // carries its expected result count and, when one, that result.
  typedef struct {
    search_req_t       item;
    int                n_typed;
    logic [ID_W-1:0]   t_id;
    logic [DIST_W-1:0] t_dist;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pqadt_req_if req_ch ();
  pqadt_rsp_if rsp_ch ();

  pq_asymmetric_distance_topk u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model state: query store, distance table, running sum, candidate buffer.
  logic [VALUE_W-1:0] qmem [NSUB*NLANE];
  logic [DIST_W-1:0]  dtab [NSUB*NCB];
  logic [DIST_W-1:0]  run_sum;
  logic [ID_W-1:0]    cand_id [NBUF];
  logic [DIST_W-1:0]  cand_dist [NBUF];
  int                 cand_cnt;
  int                 reg_m, reg_w, reg_ks, reg_keep;

  // Written-entry tracking, so stimulus never reads a store entry before it exists.
  bit q_written [NSUB*NLANE];
  bit t_written [NSUB*NCB];
  int tab_cens [NSUB][$];

  neighbor_t nearest_q [$];   // expected results, oldest first
  neighbor_t fresh_hits [$];  // results of the latest request

  int  errors;
  bit  calm;       // no idling on either side
  bit  hold_rx;    // ask the receiver for one long hold-off

  function automatic int clamp_reg(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  // Store a finished vector; on a full buffer replace the first worst entry if dval is smaller.
  function automatic void buffer_vector(input logic [ID_W-1:0] id,
                                        input logic [DIST_W-1:0] dval);
    int cap;
    int worst;
    logic [DIST_W-1:0] worst_d;
    cap = 2 * clamp_reg(reg_keep, NKEEP);
    if (cand_cnt < cap) begin
      cand_id[cand_cnt]   = id;
      cand_dist[cand_cnt] = dval;
      cand_cnt++;
      return;
    end
    worst   = 0;
    worst_d = cand_dist[0];
    for (int j = 1; j < cand_cnt; j++) begin
      if (cand_dist[j] > worst_d) begin
        worst_d = cand_dist[j];
        worst   = j;
      end
    end
    if (dval < worst_d) begin
      cand_id[worst]   = id;
      cand_dist[worst] = dval;
    end
  endfunction

  // Advance the model by one request; results land in fresh_hits.
  function automatic void search_step(input search_req_t it);
    int m, w, ks, keep, n, best, qi, ti;
    logic signed [VALUE_W:0] diff;
    logic [VALUE_W:0] mag;
    logic [DIST_W-1:0] sq, e, bd, tdist;
    logic [ID_W-1:0] tid;
    neighbor_t hit;
    m  = clamp_reg(reg_m, NSUB);
    w  = clamp_reg(reg_w, NLANE);
    ks = clamp_reg(reg_ks, NCB);
    fresh_hits.delete();
    case (it.op)
      OP_QUERY: begin
        qi = int'(it.sub) * NLANE + int'(it.lane);
        qmem[qi] = it.value;
        q_written[qi] = 1'b1;
      end
      OP_CODEBOOK: begin
        if (it.sub < m && it.lane < w && it.cen < ks) begin
          qi   = int'(it.sub) * NLANE + int'(it.lane);
          ti   = int'(it.sub) * NCB + int'(it.cen);
          diff = $signed({qmem[qi][VALUE_W-1], qmem[qi]})
               - $signed({it.value[VALUE_W-1], it.value});
          mag  = diff[VALUE_W] ? -diff : diff;
          sq   = DIST_W'(mag) * DIST_W'(mag);
          dtab[ti] = (it.lane == 0) ? sq : add_sat(dtab[ti], sq);
          if (!t_written[ti]) tab_cens[it.sub].push_back(int'(it.cen));
          t_written[ti] = 1'b1;
        end
      end
      OP_CODE: begin
        if (it.sub < m) begin
          e = dtab[int'(it.sub) * NCB + int'(it.code)];
          run_sum = (it.sub == 0) ? e : add_sat(run_sum, e);
          if (it.sub == m - 1) buffer_vector(it.vid, run_sum);
        end
      end
      default: begin
        keep = clamp_reg(reg_keep, NKEEP);
        n = (cand_cnt < keep) ? cand_cnt : keep;
        for (int s = 0; s < n; s++) begin
          best = s;
          bd   = cand_dist[s];
          for (int t = s + 1; t < cand_cnt; t++) begin
            if (cand_dist[t] < bd) begin
              bd   = cand_dist[t];
              best = t;
            end
          end
          tid = cand_id[s];
          tdist = cand_dist[s];
          cand_id[s] = cand_id[best];
          cand_dist[s] = cand_dist[best];
          cand_id[best] = tid;
          cand_dist[best] = tdist;
          hit.rank = RANK_W'(s);
          hit.id   = cand_id[s];
          hit.dval = cand_dist[s];
          hit.last = (s + 1 == n);
          fresh_hits.push_back(hit);
        end
        cand_cnt = 0;
      end
    endcase
  endfunction

  function automatic int gap_draw();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Predict, then offer the request until the block takes it.
  task automatic issue(input search_req_t it);
    int gap;
    search_step(it);
    foreach (fresh_hits[i]) nearest_q.push_back(fresh_hits[i]);
    gap = gap_draw();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= it.op;
    req_ch.subspace  <= it.sub;
    req_ch.lane      <= it.lane;
    req_ch.centroid  <= it.cen;
    req_ch.value     <= it.value;
    req_ch.code      <= it.code;
    req_ch.vector_id <= it.vid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic mk_issue(input opcode_t op, input int sub, input int lane, input int cen,
                          input logic [VALUE_W-1:0] value, input int code,
                          input logic [ID_W-1:0] vid);
    search_req_t it;
    it.op = op;
    it.sub = SUBSPACE_W'(sub);
    it.lane = LANE_W'(lane);
    it.cen = CENTROID_W'(cen);
    it.value = value;
    it.code = CODE_W'(code);
    it.vid = vid;
    issue(it);
  endtask

  // Drop valid, drain results, then let a block still busy on a silent request finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_regs(input int m, input int w, input int ks, input int keep);
    cfg_en <= 1'b1; cfg_index <= CFG_NUM_SUBSPACES;  cfg_data <= CFG_DATA_W'(m);
    @(posedge clk);
    cfg_index <= CFG_SUBSPACE_WIDTH; cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_CODEBOOK_SIZE;  cfg_data <= CFG_DATA_W'(ks);
    @(posedge clk);
    cfg_index <= CFG_KEEP_COUNT;     cfg_data <= CFG_DATA_W'(keep);
    @(posedge clk);
    cfg_en <= 1'b0;
    reg_m = m & 7'h7F;
    reg_w = w & 5'h1F;
    reg_ks = ks & 9'h1FF;
    reg_keep = keep & 6'h3F;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return VALUE_W'($urandom_range(0, 3)) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Make sure subspace sub has at least one table entry to select.
  task automatic ensure_entry(input int sub);
    int cen;
    if (tab_cens[sub].size() != 0) return;
    cen = $urandom_range(0, clamp_reg(reg_ks, NCB) - 1);
    if (!q_written[sub * NLANE]) mk_issue(OP_QUERY, sub, 0, 0, pick_value(), 0, 0);
    mk_issue(OP_CODEBOOK, sub, 0, cen, pick_value(), 0, 0);
  endtask

  // Codebook request; out-of-range fields are left alone and dropped by the block.
  task automatic rand_codebook();
    int m, w, ks, sub, lane, cen;
    m = clamp_reg(reg_m, NSUB);
    w = clamp_reg(reg_w, NLANE);
    ks = clamp_reg(reg_ks, NCB);
    sub  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, m - 1) : $urandom_range(0, 63);
    lane = ($urandom_range(0, 3) != 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 15);
    cen  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, ks - 1) : $urandom_range(0, 255);
    if (sub < m && lane < w && cen < ks) begin
      if (lane > 0 && !t_written[sub * NCB + cen]) lane = 0;
      if (!q_written[sub * NLANE + lane])
        mk_issue(OP_QUERY, sub, lane, 0, pick_value(), 0, 0);
    end
    mk_issue(OP_CODEBOOK, sub, lane, cen, pick_value(), 0, 0);
  endtask

  // One vector: mostly whole, sometimes cut short or started midway.
  task automatic rand_vector();
    int m, first, cnt, code;
    logic [ID_W-1:0] vid;
    m = clamp_reg(reg_m, NSUB);
    vid = $urandom;
    first = 0;
    cnt = m;
    if ($urandom_range(0, 7) == 0) begin
      first = $urandom_range(0, m - 1);
      cnt = $urandom_range(1, m - first);
    end
    for (int s = first; s < first + cnt; s++) begin
      ensure_entry(s);
      code = tab_cens[s][$urandom_range(0, tab_cens[s].size() - 1)];
      mk_issue(OP_CODE, s, $urandom_range(0, 15), $urandom_range(0, 255), $urandom,
               code, vid);
    end
  endtask

  task automatic rand_phase(input int rounds);
    int m;
    m = clamp_reg(reg_m, NSUB);
    for (int s = 0; s < m; s++) ensure_entry(s);
    for (int r = 0; r < rounds; r++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:  rand_codebook();
        3, 4:     mk_issue(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                           $urandom_range(0, 255), pick_value(), $urandom_range(0, 255),
                           $urandom);
        5:        mk_issue(OP_CODE, (m < NSUB) ? $urandom_range(m, 63) : m - 1 + 0 * m,
                           0, 0, 0, (m < NSUB) ? $urandom_range(0, 255)
                           : tab_cens[m - 1][0], $urandom);
        6, 7:     mk_issue(OP_FINISH, $urandom_range(0, 63), $urandom_range(0, 15),
                           $urandom_range(0, 255), $urandom, $urandom_range(0, 255),
                           $urandom);
        default:  rand_vector();
      endcase
    end
    mk_issue(OP_FINISH, 0, 0, 0, 0, 0, 0);
  endtask

  directed_row_t dir_rows [20];

  // Stimulus: directed table, then random phases under several settings.
  initial begin
    search_req_t it;
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = CFG_NUM_SUBSPACES;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_QUERY;
    req_ch.subspace = '0;
    req_ch.lane = '0;
    req_ch.centroid = '0;
    req_ch.value = '0;
    req_ch.code = '0;
    req_ch.vector_id = '0;
    errors = 0;
    calm = 1'b0;
    hold_rx = 1'b0;
    run_sum = '0;
    cand_cnt = 0;
    reg_m = 8; reg_w = 4; reg_ks = 256; reg_keep = 16;

    // Directed rows run with two subspaces, one lane, four centroids, keep one.
    dir_rows = '{
      '{'{OP_FINISH,   0,  0,   0, 32'h0,         0, 32'h0},         0, 0, 0},
      '{'{OP_QUERY,    0,  0,   0, 32'h7FFF_FFFF, 0, 32'h0},        -1, 0, 0},
      '{'{OP_QUERY,    1,  0,   0, 32'h8000_0000, 0, 32'h0},        -1, 0, 0},
      '{'{OP_QUERY,   63, 15,   0, 32'h1234_5678, 0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 0,  0,   0, 32'h8000_0000, 0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 1,  0,   0, 32'h7FFF_FFFF, 0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 0,  0,   1, 32'h7FFF_FFFF, 0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 1,  0,   1, 32'h8000_0000, 0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 0,  1,   0, 32'h0,         0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 2,  0,   0, 32'h0,         0, 32'h0},        -1, 0, 0},
      '{'{OP_CODEBOOK, 0,  0, 255, 32'h0,         0, 32'h0},        -1, 0, 0},
      '{'{OP_CODE,     0,  0,   0, 32'h0,         0, 32'h0},        -1, 0, 0},
      '{'{OP_CODE,     1,  0,   0, 32'h0,         0, 32'hFFFF_FFFF}, -1, 0, 0},
      '{'{OP_CODE,     0,  0,   0, 32'h0,         1, 32'h0},        -1, 0, 0},
      '{'{OP_CODE,     1,  0,   0, 32'h0,         1, 32'h0},        -1, 0, 0},
      '{'{OP_CODE,    63,  0,   0, 32'h0,       255, 32'h5},        -1, 0, 0},
      '{'{OP_CODE,     0,  0,   0, 32'h0,         1, 32'h7},        -1, 0, 0},
      '{'{OP_CODE,     1,  0,   0, 32'h0,         0, 32'h7},        -1, 0, 0},
      '{'{OP_FINISH,   0,  0,   0, 32'h0,         0, 32'h0},         1, 32'h0, 64'h0},
      '{'{OP_FINISH,   0,  0,   0, 32'h0,         0, 32'h0},         0, 0, 0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: an empty buffer, extreme values, dropped requests,
    // saturation of the sum, and a replace on a full buffer.
    write_regs(2, 1, 4, 1);
    foreach (dir_rows[i]) begin
      it = dir_rows[i].item;
      if (dir_rows[i].n_typed < 0) begin
        issue(it);
      end else begin
        search_step(it);
        if (fresh_hits.size() != dir_rows[i].n_typed)
          $error("row %0d: typed count %0d, model count %0d", i, dir_rows[i].n_typed,
                 fresh_hits.size());
        if (dir_rows[i].n_typed == 1)
          nearest_q.push_back('{0, dir_rows[i].t_id, dir_rows[i].t_dist, 1'b1});
        // Replay onto the block only; the model already stepped.
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= it.op;
        req_ch.subspace  <= it.sub;
        req_ch.lane      <= it.lane;
        req_ch.centroid  <= it.cen;
        req_ch.value     <= it.value;
        req_ch.code      <= it.code;
        req_ch.vector_id <= it.vid;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
      end
    end

    // Random part: all-minimum, small, wide register values, pressure, reset values.
    settle();
    write_regs(0, 0, 0, 0);
    rand_phase(8);
    settle();
    write_regs(3, 2, 5, 2);
    rand_phase(6);
    settle();
    write_regs(2, 31, 511, 63);
    rand_phase(4);
    settle();
    write_regs(2, 16, 256, 32);
    rand_phase(6);
    // Long receiver hold while the sender keeps offering requests.
    for (int v = 0; v < 10; v++) rand_vector();
    hold_rx = 1'b1;
    mk_issue(OP_FINISH, 0, 0, 0, 0, 0, 0);
    for (int v = 0; v < 2; v++) rand_vector();
    mk_issue(OP_FINISH, 0, 0, 0, 0, 0, 0);
    settle();
    calm = 1'b1;
    write_regs(8, 4, 256, 16);
    rand_phase(2);
    calm = 1'b0;
    rand_phase(1);

    settle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls, one long hold on request, field checks.
  initial begin
    neighbor_t exp_hit;
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        stall = gap_draw();
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (nearest_q.size() == 0) begin
        $error("result with nothing expected: id %0h dist %0h", rsp_ch.result_id,
               rsp_ch.distance);
        errors++;
      end else begin
        exp_hit = nearest_q.pop_front();
        if (rsp_ch.rank !== exp_hit.rank) begin
          $error("rank: expected %0d, actual %0d", exp_hit.rank, rsp_ch.rank);
          errors++;
        end
        if (rsp_ch.result_id !== exp_hit.id) begin
          $error("result_id: expected %0h, actual %0h", exp_hit.id, rsp_ch.result_id);
          errors++;
        end
        if (rsp_ch.distance !== exp_hit.dval) begin
          $error("distance: expected %0h, actual %0h", exp_hit.dval, rsp_ch.distance);
          errors++;
        end
        if (rsp_ch.last !== exp_hit.last) begin
          $error("last: expected %0b, actual %0b", exp_hit.last, rsp_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
